// ----- design/slfd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package slfd_pkg;

    localparam int BYTE_W      = 8;
    localparam int INDEX_W     = 11;
    localparam int LENGTH_W    = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hA5;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h5A;

    // Request kinds carried on s_tuser.
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Slot layout: sync bytes at 0 and 1, type at 2, length at 3 (low) and 4 (high).
    localparam int SYNC_FIRST_OFFSET  = 0;
    localparam int SYNC_SECOND_OFFSET = 1;
    localparam int TYPE_OFFSET        = 2;
    localparam int LEN_LO_OFFSET      = 3;
    localparam int LEN_HI_OFFSET      = 4;
    localparam int HEADER_BYTES       = 5;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_SECOND,
        ST_BODY
    } sync_state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

    typedef struct packed {
        logic                done;
        logic [BYTE_W-1:0]   frame_type;
        logic [LENGTH_W-1:0] frame_length;
    } frame_info_t;

endpackage

`default_nettype wire

// ----- design/slfd_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module slfd_store #(
    parameter int SLOT_COUNT = 8,
    parameter int SLOT_BYTES = 2048
) (
    input  wire logic                                          aclk,
    input  wire slfd_pkg::mem_ctl_t                            mem_ctl,
    input  wire logic [$clog2(SLOT_COUNT*SLOT_BYTES)-1:0]      mem_addr,
    input  wire logic [slfd_pkg::BYTE_W-1:0]                   mem_wdata,
    output logic [slfd_pkg::BYTE_W-1:0]                        rd_data
);
    import slfd_pkg::*;

    localparam int DEPTH = SLOT_COUNT * SLOT_BYTES;

    logic [BYTE_W-1:0] mem_reg [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // Single port, registered read. Reads and writes never share a cycle.
    always_ff @(posedge aclk) begin
        if (mem_ctl.wr_en) begin
            mem_reg[mem_addr] <= mem_wdata;
        end
        if (mem_ctl.rd_en) begin
            rd_data_reg <= mem_reg[mem_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- design/slfd_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module slfd_ctrl #(
    parameter int SLOT_COUNT = 8,
    parameter int SLOT_BYTES = 2048
) (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire logic                                          accept,
    input  wire logic                                          mode,
    input  wire logic [slfd_pkg::BYTE_W-1:0]                   byte_in,
    input  wire logic [slfd_pkg::INDEX_W-1:0]                  read_index,
    output slfd_pkg::mem_ctl_t                                 mem_ctl,
    output logic [$clog2(SLOT_COUNT*SLOT_BYTES)-1:0]           mem_addr,
    output logic [slfd_pkg::BYTE_W-1:0]                        mem_wdata,
    output slfd_pkg::frame_info_t                              info
);
    import slfd_pkg::*;

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int PW = $clog2(SLOT_BYTES);
    localparam int RW = ((PW > INDEX_W) ? PW : INDEX_W) + 1;
    localparam int CW = LENGTH_W + 1;

    sync_state_t         state_reg, state_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [SW-1:0]       cur_slot_reg, cur_slot_next;
    logic [SW-1:0]       last_slot_reg, last_slot_next;
    logic [LENGTH_W-1:0] len_reg, len_next;
    logic                seen_reg, seen_next;

    // Shadow copies of the header bytes, kept in step with every store write
    // to offsets 2 to 4 of the current slot, so no memory read is needed.
    logic [BYTE_W-1:0]   cur_type_reg, cur_type_next;
    logic [BYTE_W-1:0]   cur_lo_reg, cur_lo_next;
    logic [BYTE_W-1:0]   cur_hi_reg, cur_hi_next;
    logic [BYTE_W-1:0]   last_type_reg, last_type_next;
    logic [LENGTH_W-1:0] last_len_reg, last_len_next;

    logic                push;
    logic                body_push;
    logic [PW-1:0]       pos_inc;
    logic [LENGTH_W-1:0] len_eff;
    logic                complete;
    logic [PW-1:0]       wr_off;
    logic [RW-1:0]       rd_sum;
    logic [PW-1:0]       rd_off;

    assign push      = accept && !mode;
    assign body_push = push && (state_reg == ST_BODY);
    assign pos_inc   = pos_reg + 1'b1;
    assign len_eff   = (pos_reg == PW'(LEN_HI_OFFSET)) ? {byte_in, cur_lo_reg} : len_reg;
    assign complete  = body_push && (pos_inc > PW'(HEADER_BYTES))
                       && (CW'(pos_inc) >= CW'(len_eff) + CW'(HEADER_BYTES));
    assign rd_sum    = RW'(read_index) + RW'(HEADER_BYTES);
    assign rd_off    = rd_sum[PW-1:0];

    always_comb begin
        state_next = state_reg;
        if (push) begin
            unique case (state_reg)
                ST_HUNT: begin
                    if (byte_in == SYNC_FIRST) begin
                        state_next = ST_SECOND;
                    end
                end
                ST_SECOND: begin
                    state_next = (byte_in == SYNC_SECOND) ? ST_BODY : ST_HUNT;
                end
                ST_BODY: begin
                    if (complete) begin
                        state_next = ST_HUNT;
                    end
                end
                default: begin
                    state_next = ST_HUNT;
                end
            endcase
        end
    end

    always_comb begin
        pos_next       = pos_reg;
        cur_slot_next  = cur_slot_reg;
        last_slot_next = last_slot_reg;
        len_next       = len_reg;
        seen_next      = seen_reg;
        cur_type_next  = cur_type_reg;
        cur_lo_next    = cur_lo_reg;
        cur_hi_next    = cur_hi_reg;
        last_type_next = last_type_reg;
        last_len_next  = last_len_reg;
        mem_ctl.wr_en  = 1'b0;
        mem_ctl.rd_en  = accept && mode;
        wr_off         = pos_reg;
        mem_wdata      = byte_in;

        if (push) begin
            unique case (state_reg)
                ST_HUNT: begin
                    if (byte_in == SYNC_FIRST) begin
                        mem_ctl.wr_en = 1'b1;
                        wr_off        = PW'(SYNC_FIRST_OFFSET);
                        pos_next      = PW'(SYNC_SECOND_OFFSET);
                    end
                end
                ST_SECOND: begin
                    if (byte_in == SYNC_SECOND) begin
                        mem_ctl.wr_en = 1'b1;
                        wr_off        = PW'(SYNC_SECOND_OFFSET);
                        pos_next      = PW'(TYPE_OFFSET);
                    end
                end
                ST_BODY: begin
                    mem_ctl.wr_en = 1'b1;
                    if (pos_reg == PW'(TYPE_OFFSET)) begin
                        cur_type_next = byte_in;
                    end
                    if (pos_reg == PW'(LEN_LO_OFFSET)) begin
                        cur_lo_next = byte_in;
                    end
                    if (pos_reg == PW'(LEN_HI_OFFSET)) begin
                        cur_hi_next = byte_in;
                        len_next    = len_eff;
                    end
                    pos_next = pos_inc;
                    if (complete) begin
                        pos_next       = '0;
                        last_slot_next = cur_slot_reg;
                        cur_slot_next  = cur_slot_reg + 1'b1;
                        seen_next      = 1'b1;
                        last_type_next = cur_type_next;
                        last_len_next  = {cur_hi_next, cur_lo_next};
                    end
                end
                default: begin
                end
            endcase
        end

        mem_addr = mem_ctl.rd_en ? {last_slot_reg, rd_off} : {cur_slot_reg, wr_off};

        // Until a frame has completed, the last slot is the current one.
        info.done         = complete;
        info.frame_type   = seen_next ? last_type_next : cur_type_next;
        info.frame_length = seen_next ? last_len_next : {cur_hi_next, cur_lo_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_HUNT;
            pos_reg       <= '0;
            cur_slot_reg  <= '0;
            last_slot_reg <= '0;
            len_reg       <= '0;
            seen_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            cur_slot_reg  <= cur_slot_next;
            last_slot_reg <= last_slot_next;
            len_reg       <= len_next;
            seen_reg      <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_type_reg  <= cur_type_next;
        cur_lo_reg    <= cur_lo_next;
        cur_hi_reg    <= cur_hi_next;
        last_type_reg <= last_type_next;
        last_len_reg  <= last_len_next;
    end

`ifndef SYNTHESIS
    a_done_restarts_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        info.done |=> (state_reg == ST_HUNT) && (pos_reg == '0))
        else $error("completed frame did not return to hunting at position zero");
    a_done_rotates_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        info.done |=> (last_slot_reg == $past(cur_slot_reg)) && seen_reg)
        else $error("completed frame did not become the last slot");
    a_access_needs_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_ctl.wr_en || mem_ctl.rd_en) |-> accept && !(mem_ctl.wr_en && mem_ctl.rd_en))
        else $error("store access without an accepted request");
`endif

endmodule

`default_nettype wire

// ----- design/sync_length_frame_decoder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Byte-stream frame decoder. Each request either pushes one stream byte (s_tuser = 0) or
// reads one payload byte of the last completed frame (s_tuser = 1). Pushed bytes hunt for
// the sync pair 0xA5, 0x5A; after sync the type byte, the little-endian 16-bit length and
// the payload are written into one of SLOT_COUNT rotating slots of SLOT_BYTES bytes, held
// in a single-port synchronous memory. Every request yields exactly one result carrying the
// type and length of the last completed frame, a done flag on m_tlast for the byte that
// completes a frame, and for reads the payload byte at offset read_index + 5 within the
// slot. A new request is taken every clock cycle unless the output is stalled; each result
// waits in stage one for the memory read, then sits in the output register. The
// one memory access per request sets that rate. The store has no reset and needs no
// clearing pass, so requests are taken right after reset. SLOT_COUNT and SLOT_BYTES must
// be powers of two.
module sync_length_frame_decoder_top #(
    parameter int SLOT_COUNT = 8,
    parameter int SLOT_BYTES = 2048
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // Bits from the lowest up: byte_in [7:0], read_index [18:8], zero [23:19].
    input  wire logic [slfd_pkg::IN_TDATA_W-1:0]      s_tdata,
    // Bits: mode [0].
    input  wire logic                                 s_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // Bits from the lowest up: frame_type [7:0], frame_length [23:8], read_byte [31:24].
    output logic [slfd_pkg::OUT_TDATA_W-1:0]          m_tdata,
    // Bits: frame_done [0].
    output logic                                      m_tlast
);
    import slfd_pkg::*;

    localparam int AW = $clog2(SLOT_COUNT * SLOT_BYTES);

    logic                accept;
    logic [BYTE_W-1:0]   byte_in;
    logic [INDEX_W-1:0]  read_index;
    mem_ctl_t            mem_ctl;
    logic [AW-1:0]       mem_addr;
    logic [BYTE_W-1:0]   mem_wdata;
    logic [BYTE_W-1:0]   rd_data;
    frame_info_t         info;

    // Stage one waits for the memory read; the output stage holds the finished result.
    logic                v1_reg;
    frame_info_t         st1_info_reg;
    logic                st1_read_reg;
    logic                out_valid_reg;
    frame_info_t         out_info_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                out_load;

    assign byte_in    = s_tdata[BYTE_W-1:0];
    assign read_index = s_tdata[BYTE_W+INDEX_W-1:BYTE_W];

    // The output register is free when empty or being drained this cycle.
    assign out_load = v1_reg && (!out_valid_reg || m_tready);
    assign s_tready = !v1_reg || out_load;
    assign accept   = s_tvalid && s_tready;

    slfd_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .mode       (s_tuser),
        .byte_in    (byte_in),
        .read_index (read_index),
        .mem_ctl    (mem_ctl),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .info       (info)
    );

    slfd_store #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_store (
        .aclk      (aclk),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .rd_data   (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                v1_reg <= 1'b1;
            end else if (out_load) begin
                v1_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The memory read register only changes on an accepted read, and a request is only
    // accepted when stage one moves on, so the read data is still in place at out_load.
    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_info_reg <= info;
            st1_read_reg <= s_tuser;
        end
        if (out_load) begin
            out_info_reg <= st1_info_reg;
            out_byte_reg <= st1_read_reg ? rd_data : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_info_reg.done;
    assign m_tdata  = {out_byte_reg, out_info_reg.frame_length, out_info_reg.frame_type};

`ifndef SYNTHESIS
    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> v1_reg)
        else $error("accepted request did not enter the read stage");
    a_stall_holds_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !out_load) |=> v1_reg && $stable(st1_info_reg) && !$past(accept))
        else $error("read stage changed while the output was stalled");
    a_done_has_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[OUT_TDATA_W-1:OUT_TDATA_W-BYTE_W] == '0))
        else $error("a completing push carried a read byte");
`endif

endmodule

`default_nettype wire

// ----- test/frame_decoder_checker.sv -----
`timescale 1ns / 1ps

module frame_decoder_checker
    import slfd_pkg::*;
#(
    parameter int SLOT_COUNT = 8,
    parameter int SLOT_BYTES = 2048
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   s_tuser,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                   m_tlast,
    output int                          error_count,
    output int                          responses_pending
);

    typedef struct {
        logic                done;
        logic [BYTE_W-1:0]   frame_type;
        logic [LENGTH_W-1:0] frame_length;
        logic [BYTE_W-1:0]   read_byte;
        bit                  type_known;
        bit                  length_known;
        bit                  byte_known;
    } frame_response_t;

    // Shadow copy of the decoder. Each store entry carries a written flag so that
    // fields coming from entries that were never filled are left unchecked.
    logic [BYTE_W-1:0] slot_mem     [SLOT_COUNT*SLOT_BYTES];
    bit                slot_written [SLOT_COUNT*SLOT_BYTES];
    sync_state_t       hunt_phase;
    int                write_pos;
    int                fill_slot;
    int                done_slot;
    int                frame_len;

    frame_response_t   predicted_responses [$];

    function automatic int mem_addr(input int slot, input int offset);
        return slot * SLOT_BYTES + (offset % SLOT_BYTES);
    endfunction

    function automatic void store_byte(input int slot, input int offset,
                                       input logic [BYTE_W-1:0] value);
        slot_mem[mem_addr(slot, offset)]     = value;
        slot_written[mem_addr(slot, offset)] = 1'b1;
    endfunction

    // Advances the sync hunt and frame fill by one stream byte; returns the done flag.
    function automatic logic advance_stream(input logic [BYTE_W-1:0] b);
        logic done;
        done = 1'b0;
        case (hunt_phase)
            ST_HUNT: begin
                if (b == SYNC_FIRST) begin
                    hunt_phase = ST_SECOND;
                    store_byte(fill_slot, SYNC_FIRST_OFFSET, SYNC_FIRST);
                    write_pos = SYNC_FIRST_OFFSET + 1;
                end
            end
            ST_SECOND: begin
                if (b == SYNC_SECOND) begin
                    hunt_phase = ST_BODY;
                    store_byte(fill_slot, SYNC_SECOND_OFFSET, SYNC_SECOND);
                    write_pos = SYNC_SECOND_OFFSET + 1;
                end else begin
                    hunt_phase = ST_HUNT;
                end
            end
            default: begin
                store_byte(fill_slot, write_pos, b);
                if (write_pos == LEN_HI_OFFSET) begin
                    frame_len = int'(slot_mem[mem_addr(fill_slot, LEN_LO_OFFSET)])
                              + int'(slot_mem[mem_addr(fill_slot, LEN_HI_OFFSET)]) * 256;
                end
                write_pos = (write_pos + 1) % SLOT_BYTES;
                if (write_pos > HEADER_BYTES && write_pos >= frame_len + HEADER_BYTES) begin
                    hunt_phase = ST_HUNT;
                    write_pos  = 0;
                    done_slot  = fill_slot;
                    fill_slot  = (fill_slot + 1) % SLOT_COUNT;
                    done       = 1'b1;
                end
            end
        endcase
        return done;
    endfunction

    task automatic decode_request(input logic mode, input logic [BYTE_W-1:0] b,
                                  input logic [INDEX_W-1:0] idx);
        frame_response_t resp;
        int              addr;
        resp.done       = 1'b0;
        resp.read_byte  = '0;
        resp.byte_known = 1'b1;
        if (mode == MODE_PUSH) begin
            resp.done = advance_stream(b);
        end else begin
            addr            = mem_addr(done_slot, int'(idx) + HEADER_BYTES);
            resp.read_byte  = slot_mem[addr];
            resp.byte_known = slot_written[addr];
        end
        resp.frame_type   = slot_mem[mem_addr(done_slot, TYPE_OFFSET)];
        resp.type_known   = slot_written[mem_addr(done_slot, TYPE_OFFSET)];
        resp.frame_length = {slot_mem[mem_addr(done_slot, LEN_HI_OFFSET)],
                             slot_mem[mem_addr(done_slot, LEN_LO_OFFSET)]};
        resp.length_known = slot_written[mem_addr(done_slot, LEN_HI_OFFSET)]
                         && slot_written[mem_addr(done_slot, LEN_LO_OFFSET)];
        predicted_responses.push_back(resp);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s, got 0x%0h, expected 0x%0h, at %0t", what, got, want, $time);
        error_count++;
    endtask

    task automatic compare_response();
        frame_response_t want;
        if (predicted_responses.size() == 0) begin
            report_mismatch("result with no request waiting", m_tdata, '0);
        end else begin
            want = predicted_responses.pop_front();
            if (m_tlast !== want.done)
                report_mismatch("frame_done", 32'(m_tlast), 32'(want.done));
            if (want.type_known && m_tdata[7:0] !== want.frame_type)
                report_mismatch("frame_type", 32'(m_tdata[7:0]), 32'(want.frame_type));
            if (want.length_known && m_tdata[23:8] !== want.frame_length)
                report_mismatch("frame_length", 32'(m_tdata[23:8]), 32'(want.frame_length));
            if (want.byte_known && m_tdata[31:24] !== want.read_byte)
                report_mismatch("read_byte", 32'(m_tdata[31:24]), 32'(want.read_byte));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            hunt_phase        = ST_HUNT;
            write_pos         = 0;
            fill_slot         = 0;
            done_slot         = 0;
            frame_len         = 0;
            error_count       = 0;
            responses_pending = 0;
        end else begin
            // A result can only leave after its request has been taken, so the output side is
            // handled first; the order only matters for an empty queue.
            if (m_tvalid && m_tready)
                compare_response();
            if (s_tvalid && s_tready)
                decode_request(s_tuser, s_tdata[7:0], s_tdata[18:8]);
            responses_pending = predicted_responses.size();
        end
    end

endmodule

// ----- test/sync_length_frame_decoder_top_tb.sv -----
`timescale 1ns / 1ps

module sync_length_frame_decoder_top_tb;

    import slfd_pkg::*;

    localparam int SLOT_COUNT = 8;
    localparam int SLOT_BYTES = 2048;

    // The first length that never completes.
    localparam int ENDLESS_FRAME = SLOT_BYTES - HEADER_BYTES;
    // Bytes sent into the frame that never completes before the run ends.
    localparam int ENDLESS_BYTES = 40;

    localparam int RANDOM_ITEMS = 380;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 20;

    // The receiver holds off for this long once, well into the run, so that the
    // block fills up and pushes back on the sender.
    localparam int HOLD_START  = 300;
    localparam int HOLD_CYCLES = 500;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = MODE_PUSH;
    logic                   m_tready = 1'b0;
    wire                    s_tready;
    wire                    m_tvalid;
    wire [OUT_TDATA_W-1:0]  m_tdata;
    wire                    m_tlast;

    int error_count;
    int responses_pending;

    // What the stimulus side knows about the last completed frame: reads are kept
    // inside the bytes that frame really wrote, or inside its header.
    int last_payload = 0;
    int item_count   = 0;
    int burst_left   = 0;

    sync_length_frame_decoder_top #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    frame_decoder_checker #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tlast           (m_tlast),
        .error_count       (error_count),
        .responses_pending (responses_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // A hung block must not keep the run going forever.
    initial begin
        #10ms;
        $display("simulation failed");
        $finish;
    end

    // Idle cycles before the next request. Mostly none or a few, now and then a long
    // gap, and from time to time a burst of back-to-back requests.
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Offers one request and returns right after the edge at which it is accepted.
    // Valid is only lowered when a gap follows, so back-to-back requests keep it high.
    task automatic push_request(input logic mode, input logic [BYTE_W-1:0] b,
                                input logic [INDEX_W-1:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(IN_TDATA_W - INDEX_W - BYTE_W){1'b0}}, idx, b};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        item_count++;
    endtask

    // The read index is meaningless for a pushed byte, so it carries random bits.
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        push_request(MODE_PUSH, b, INDEX_W'($urandom_range(0, SLOT_BYTES - 1)));
    endtask

    task automatic read_payload(input int idx);
        push_request(MODE_READ, BYTE_W'($urandom_range(0, 255)), INDEX_W'(idx));
    endtask

    // Indexes near the top of the range wrap around onto the header bytes.
    task automatic read_last_frame();
        if ($urandom_range(0, 6) == 0)
            read_payload(SLOT_BYTES - HEADER_BYTES + $urandom_range(0, HEADER_BYTES - 1));
        else
            read_payload($urandom_range(0, last_payload - 1));
    endtask

    // A byte that can never start a sync while the decoder is hunting. The decoder
    // ignores it, so it does not count toward the request total.
    task automatic push_noise();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom_range(0, 254));
        if (b >= SYNC_FIRST) b = b + 1'b1;
        push_byte(b);
        item_count--;
    endtask

    // A first sync byte followed by anything but the second one; sometimes that
    // byte is another first sync byte, which must not restart the pair.
    task automatic push_broken_sync();
        logic [BYTE_W-1:0] b;
        push_byte(SYNC_FIRST);
        if ($urandom_range(0, 2) == 0) begin
            b = SYNC_FIRST;
        end else begin
            b = BYTE_W'($urandom_range(0, 254));
            if (b >= SYNC_SECOND) b = b + 1'b1;
        end
        push_byte(b);
    endtask

    // A complete frame. A zero length still takes one payload byte.
    task automatic send_frame(input logic [BYTE_W-1:0] frame_type,
                              input logic [LENGTH_W-1:0] len);
        int count;
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        push_byte(frame_type);
        push_byte(len[7:0]);
        push_byte(len[15:8]);
        count = (len == 0) ? 1 : int'(len);
        repeat (count) push_byte(BYTE_W'($urandom_range(0, 255)));
        last_payload = count;
    endtask

    // A frame whose length is too large to ever finish. A stretch of its payload is
    // sent and it is left open, with reads of the last finished frame mixed in.
    task automatic send_endless_frame();
        logic [LENGTH_W-1:0] len;
        if ($urandom_range(0, 1) == 0)
            len = LENGTH_W'(ENDLESS_FRAME);
        else
            len = {BYTE_W'($urandom_range(8, 255)), BYTE_W'($urandom_range(0, 255))};
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        push_byte(BYTE_W'($urandom_range(0, 255)));
        push_byte(len[7:0]);
        push_byte(len[15:8]);
        repeat (ENDLESS_BYTES) begin
            push_byte(BYTE_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) == 0) read_last_frame();
        end
    endtask

    // Result side: random stalls of mostly short and a few long stretches, runs with
    // no stall at all, and one long hold-off counted here in cycles.
    initial begin : result_sink
        int stall_left;
        int ready_left;
        int cycle_count;
        int r;
        stall_left  = 0;
        ready_left  = 0;
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count == HOLD_START) stall_left = HOLD_CYCLES;
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (ready_left > 0) begin
                ready_left--;
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    ready_left = $urandom_range(20, 80);
                    m_tready   <= 1'b1;
                end else if (r < 60) begin
                    m_tready <= 1'b1;
                end else begin
                    if (r < 88)
                        stall_left = $urandom_range(1, 3) - 1;
                    else if (r < 98)
                        stall_left = $urandom_range(4, 10) - 1;
                    else
                        stall_left = $urandom_range(20, 60) - 1;
                    m_tready <= 1'b0;
                end
            end
        end
    end

    initial begin : request_source
        int r;
        int len;
        int wait_cycles;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. Bytes the hunter must ignore, a first sync byte followed by
        // another one (which is not taken as the start of a new pair), then frames at
        // the extremes of the type byte with a zero length and a short length.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(SYNC_FIRST);
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        send_frame(8'h00, 16'd0);
        read_payload(0);
        read_payload(SLOT_BYTES - HEADER_BYTES + SYNC_FIRST_OFFSET);
        read_payload(SLOT_BYTES - HEADER_BYTES + LEN_HI_OFFSET);
        send_frame(8'hFF, 16'd3);
        read_payload(2);
        read_payload(SLOT_BYTES - HEADER_BYTES + TYPE_OFFSET);

        // Random part: mostly well-formed frames with random contents and reads of
        // them, mixed with noise, broken sync pairs and bursts of reads.
        item_count = 0;
        while (item_count < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    len = $urandom_range(0, 6);
                else if (r < 90)
                    len = $urandom_range(7, 24);
                else
                    len = $urandom_range(25, 120);
                send_frame(BYTE_W'($urandom_range(0, 255)), LENGTH_W'(len));
                repeat ($urandom_range(0, 3)) read_last_frame();
            end else if (r < 80) begin
                repeat ($urandom_range(1, 4)) push_noise();
            end else if (r < 90) begin
                push_broken_sync();
            end else begin
                repeat ($urandom_range(1, 5)) read_last_frame();
            end
        end

        // A frame that never completes leaves the decoder stuck in it, so it comes last.
        send_endless_frame();
        s_tvalid <= 1'b0;

        wait_cycles = 0;
        while (responses_pending != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge aclk);
            wait_cycles++;
        end
        if (responses_pending != 0) begin
            $display("simulation failed");
        end else begin
            // A few more cycles catch any stray result behind the last one.
            repeat (TAIL_CYCLES) @(posedge aclk);
            if (error_count == 0)
                $display("simulation ok");
            else
                $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/slfd_pkg.sv
design/slfd_store.sv
design/slfd_ctrl.sv
design/sync_length_frame_decoder_top.sv
test/frame_decoder_checker.sv
test/sync_length_frame_decoder_top_tb.sv
